>>> hw/rtl/ipv4fhb_pkg.sv
`default_nettype none

package ipv4fhb_pkg;

    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    localparam logic REG_LOCAL_ADDRESS = 1'b0;
    localparam logic REG_FRAGMENT_UNITS = 1'b1;

    localparam logic [7:0] UNITS_MIN = 8'd128;
    localparam logic [7:0] UNITS_MAX = 8'd185;
    localparam logic [7:0] UNITS_RESET = 8'd185;
    localparam logic [10:0] HDR_BYTES = 11'd20;
    localparam logic [15:0] VER_IHL_TOS = 16'h4500;
    localparam logic [7:0] HDR_TTL = 8'd64;

    typedef struct packed {
        logic [15:0] payload_length;
        logic [31:0] dest_address;
        logic [7:0] protocol_number;
    } in_item_t;

    typedef struct packed {
        logic [10:0] total_length;
        logic [15:0] identification;
        logic more_fragments;
        logic [12:0] fragment_offset;
        logic [7:0] protocol_out;
        logic [31:0] dest_out;
        logic [15:0] header_checksum;
        logic [15:0] payload_start;
        logic [10:0] fragment_bytes;
        logic last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [31:0] local_address;
        logic [7:0] fragment_payload_units;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic frag;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_FRAG,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/ipv4fhb_regs.sv
`default_nettype none

module ipv4fhb_regs
    import ipv4fhb_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t cfg_reg, cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_LOCAL_ADDRESS: cfg_next.local_address = pwdata;
                REG_FRAGMENT_UNITS: cfg_next.fragment_payload_units = pwdata[7:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LOCAL_ADDRESS: prdata = cfg_reg.local_address;
            REG_FRAGMENT_UNITS: prdata = {24'd0, cfg_reg.fragment_payload_units};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.local_address <= '0;
            cfg_reg.fragment_payload_units <= UNITS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ipv4fhb_ctrl.sv
`default_nettype none

module ipv4fhb_ctrl
    import ipv4fhb_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire status_t st,
    output cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup = 1'b1;
                state_next = ST_FRAG;
            end
            ST_FRAG: begin
                cmd.frag = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    state_next = st.last ? ST_IDLE : ST_FRAG;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_emit_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && cmd.emit) |=> (state_reg == ST_IDLE || state_reg == ST_FRAG))
        else $error("emit did not leave the emit state");
    a_load_to_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && cmd.load) |=> (state_reg == ST_SETUP))
        else $error("accepted request did not start setup");
    a_emit_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && cmd.emit && st.last) |=> s_ready)
        else $error("last fragment did not return to idle");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/ipv4fhb_dpath.sv
`default_nettype none

module ipv4fhb_dpath
    import ipv4fhb_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire in_item_t s_data,
    input  wire cfg_t     cfg,
    input  wire cmd_t     cmd,
    output status_t       st,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data
);

    logic [15:0] id_cnt_reg, id_cnt_next;
    logic [15:0] len_reg;
    logic [31:0] dst_reg;
    logic [7:0] proto_reg;
    logic [15:0] id_reg;
    logic [18:0] base_reg;
    logic [10:0] max_bytes_reg;
    logic [15:0] start_reg, start_next;
    logic [10:0] bytes_reg;
    logic last_reg;
    logic out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    logic [7:0] units;
    logic [18:0] base_sum;
    logic [15:0] remain;
    logic frag_last;
    logic [10:0] total;
    logic [15:0] flags_off;
    logic [19:0] csum_sum;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] start_inc;

    always_comb begin
        if (cfg.fragment_payload_units < UNITS_MIN) begin
            units = UNITS_MIN;
        end else if (cfg.fragment_payload_units > UNITS_MAX) begin
            units = UNITS_MAX;
        end else begin
            units = cfg.fragment_payload_units;
        end
    end

    assign base_sum = 19'(VER_IHL_TOS) + 19'(id_reg) + 19'({HDR_TTL, proto_reg})
                    + 19'(cfg.local_address[31:16]) + 19'(cfg.local_address[15:0])
                    + 19'(dst_reg[31:16]) + 19'(dst_reg[15:0]);

    assign remain = len_reg - start_reg;
    assign frag_last = remain <= 16'(max_bytes_reg);

    assign total = HDR_BYTES + bytes_reg;
    assign flags_off = {2'b00, !last_reg, start_reg[15:3]};
    assign csum_sum = 20'(base_reg) + 20'(total) + 20'(flags_off);
    assign fold1 = 17'(csum_sum[15:0]) + 17'(csum_sum[19:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);
    assign start_inc = start_reg + 16'(max_bytes_reg);

    assign st.last = last_reg;
    assign st.out_free = !out_valid_reg || m_ready;

    always_comb begin
        id_cnt_next = id_cnt_reg;
        start_next = start_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        if (cmd.load) begin
            id_cnt_next = id_cnt_reg + 16'd1;
        end
        if (cmd.setup) begin
            start_next = '0;
        end
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            out_valid_next = 1'b1;
            out_next.total_length = total;
            out_next.identification = id_reg;
            out_next.more_fragments = !last_reg;
            out_next.fragment_offset = start_reg[15:3];
            out_next.protocol_out = proto_reg;
            out_next.dest_out = dst_reg;
            out_next.header_checksum = ~fold2;
            out_next.payload_start = start_reg;
            out_next.fragment_bytes = bytes_reg;
            out_next.last_of_run = last_reg;
            start_next = start_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            id_cnt_reg <= id_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            len_reg <= s_data.payload_length;
            dst_reg <= s_data.dest_address;
            proto_reg <= s_data.protocol_number;
            id_reg <= id_cnt_reg;
        end
        if (cmd.setup) begin
            base_reg <= base_sum;
            max_bytes_reg <= {units, 3'b000};
        end
        if (cmd.frag) begin
            last_reg <= frag_last;
            bytes_reg <= frag_last ? remain[10:0] : max_bytes_reg;
        end
        start_reg <= start_next;
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

`ifndef SYNTHESIS
    a_id_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && cmd.load) |=> (id_cnt_reg == $past(id_cnt_reg) + 16'd1))
        else $error("packet id did not advance on accepted request");
    a_total_len: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.total_length == out_reg.fragment_bytes + HDR_BYTES))
        else $error("total length disagrees with fragment bytes");
    a_mf_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.more_fragments != out_reg.last_of_run))
        else $error("more fragments flag disagrees with last fragment");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/ipv4_fragment_header_builder.sv
// Channel   | Ports                          | Beat
// ----------+--------------------------------+------------------------------------
// request   | s_valid, s_ready, s_data       | one send request
// header    | m_valid, m_ready, m_data       | one fragment header description
// config    | psel, penable, pwrite, paddr,  | one register write or read
//           | pwdata, prdata, pready         |
//
// A request is accepted in the idle state and followed by a setup step, then
// each fragment takes a sizing step, then a checksum and output register load.
// The output register holds a header while the next request is accepted.
// Synchronous reset clears the packet id and local address; units reset to 185.
// A stalled header beat stalls fragment generation in the checksum step.
`default_nettype none

module ipv4_fragment_header_builder
    import ipv4fhb_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_item_t          s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_item_t              m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    cfg_t cfg;
    cmd_t cmd;
    status_t st;

    ipv4fhb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ipv4fhb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    ipv4fhb_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cfg     (cfg),
        .cmd     (cmd),
        .st      (st),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
